// ===== sv/aahmd_pkg.sv =====
// shared types and constants of the accelerometer averaging block
`default_nettype none

package aahmd_pkg;

    localparam int AVG_W    = 11;
    localparam int SAMPLE_W = 10;
    localparam int THR_W    = 11;
    localparam int AXIS_W   = 2;
    localparam int NUM_AXES = 3;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // op codes of an input item
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // axis codes
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
    localparam logic [1:0] REG_HIT_THR     = 2'd1;
    localparam logic [1:0] REG_MOTION_THR  = 2'd2;

    // classified item handed from front to back
    typedef struct packed {
        logic                    is_tick;
        logic [AXIS_W-1:0]       axis;
        logic signed [AVG_W-1:0] delta;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic signed [AVG_W-1:0] avg_x;
        logic signed [AVG_W-1:0] avg_y;
        logic signed [AVG_W-1:0] avg_z;
        logic                    hit_now;
        logic                    motion_now;
        logic                    hit_seen;
        logic                    motion_seen;
        logic                    averages_valid;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/accel_average_hit_motion_detect.sv =====
// top level of the accelerometer averaging and hit/motion detector
// usage
//   input channel: push with op, axis, sample; an item is taken at a clock edge
//   where push is high and full is low. op selects a converter sample or a
//   timer tick; a sample for axis code three is taken and dropped
//   result channel: one result item per tick, none per sample; the oldest
//   result sits on the avg/flag ports while empty is low and leaves on pop
//   configuration: apb write of zero_offset, hit_threshold, motion_threshold
//   at byte addresses 0, 4 and 8, only while the block is idle
// timing
//   one item per cycle sustained while full is low; a tick's result passes
//   through the front queue, then through the back end into the result
//   queue, whose oldest entry drives the result ports
//   the back end does a tick's reciprocal multiply, compare and flag update
//   in the cycle it takes the item from the front queue
// stall and reset
//   when pop stays low the result queue fills, the back end holds ticks and
//   the front queue then raises full; samples ahead of a held tick still drain
//   reset clears accumulators, counts, averages and sticky flags and loads
//   the register reset values; no clearing pass is needed
`default_nettype none

module accel_average_hit_motion_detect #(
    parameter int SAMPLES_PER_AVERAGE = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input channel
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                op,
    input  wire logic [aahmd_pkg::AXIS_W-1:0]        axis,
    input  wire logic [aahmd_pkg::SAMPLE_W-1:0]      sample,
    // result channel
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [aahmd_pkg::AVG_W-1:0]       avg_x,
    output logic signed [aahmd_pkg::AVG_W-1:0]       avg_y,
    output logic signed [aahmd_pkg::AVG_W-1:0]       avg_z,
    output logic                                     hit_now,
    output logic                                     motion_now,
    output logic                                     hit_seen,
    output logic                                     motion_seen,
    output logic                                     averages_valid,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [aahmd_pkg::APB_AW-1:0]        paddr,
    input  wire logic [aahmd_pkg::APB_DW-1:0]        pwdata,
    output logic [aahmd_pkg::APB_DW-1:0]             prdata,
    output logic                                     pready
);

    localparam int CMD_W = $bits(aahmd_pkg::cmd_t);
    localparam int RES_W = $bits(aahmd_pkg::result_t);

    // configuration registers
    logic [aahmd_pkg::SAMPLE_W-1:0] zero_offset_reg;
    logic [aahmd_pkg::THR_W-1:0]    hit_thr_reg;
    logic [aahmd_pkg::THR_W-1:0]    motion_thr_reg;
    logic                           cfg_write;
    logic [1:0]                     reg_index;

    // front to back queue
    logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
    aahmd_pkg::cmd_t      cmd_in, cmd_out;
    logic [CMD_W-1:0]     cmd_out_bits;

    // back to result queue
    logic                 res_push, res_full;
    aahmd_pkg::result_t   res_in, res_out;
    logic [RES_W-1:0]     res_out_bits;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= 10'd512;
            hit_thr_reg     <= 11'd200;
            motion_thr_reg  <= 11'd20;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                aahmd_pkg::REG_ZERO_OFFSET: zero_offset_reg <= pwdata[aahmd_pkg::SAMPLE_W-1:0];
                aahmd_pkg::REG_HIT_THR:     hit_thr_reg     <= pwdata[aahmd_pkg::THR_W-1:0];
                aahmd_pkg::REG_MOTION_THR:  motion_thr_reg  <= pwdata[aahmd_pkg::THR_W-1:0];
                default:                    ; // unmapped address, write ignored
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_index)
            aahmd_pkg::REG_ZERO_OFFSET: prdata = aahmd_pkg::APB_DW'(zero_offset_reg);
            aahmd_pkg::REG_HIT_THR:     prdata = aahmd_pkg::APB_DW'(hit_thr_reg);
            aahmd_pkg::REG_MOTION_THR:  prdata = aahmd_pkg::APB_DW'(motion_thr_reg);
            default:                    prdata = '0;
        endcase
    end

    // front: takes every item, forwards those that matter
    aahmd_front u_front (
        .push        (push),
        .op          (op),
        .axis        (axis),
        .sample      (sample),
        .zero_offset (zero_offset_reg),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // an item is taken whenever the front queue has room, dropped ones too
    assign full = cmd_full;

    aahmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out_bits),
        .empty     (cmd_empty)
    );

    assign cmd_out = aahmd_pkg::cmd_t'(cmd_out_bits);

    // back: accumulators, averages and detection state
    aahmd_back #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_empty        (cmd_empty),
        .cmd              (cmd_out),
        .cmd_pop          (cmd_pop),
        .hit_threshold    (hit_thr_reg),
        .motion_threshold (motion_thr_reg),
        .res_full         (res_full),
        .res_push         (res_push),
        .res              (res_in)
    );

    // result queue parts the back end from the receiver
    aahmd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out_bits),
        .empty     (empty)
    );

    assign res_out        = aahmd_pkg::result_t'(res_out_bits);
    assign avg_x          = res_out.avg_x;
    assign avg_y          = res_out.avg_y;
    assign avg_z          = res_out.avg_z;
    assign hit_now        = res_out.hit_now;
    assign motion_now     = res_out.motion_now;
    assign hit_seen       = res_out.hit_seen;
    assign motion_seen    = res_out.motion_seen;
    assign averages_valid = res_out.averages_valid;

endmodule

`default_nettype wire

// ===== sv/aahmd_fifo.sv =====
// small first-word-fall-through queue
`default_nettype none

module aahmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/aahmd_front.sv =====
// front end: classifies items and removes the zero offset
`default_nettype none

module aahmd_front (
    input  wire logic                             push,
    input  wire logic                             op,
    input  wire logic [aahmd_pkg::AXIS_W-1:0]     axis,
    input  wire logic [aahmd_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic [aahmd_pkg::SAMPLE_W-1:0]   zero_offset,
    input  wire logic                             cmd_full,
    output logic                                  cmd_push,
    output aahmd_pkg::cmd_t                       cmd
);

    logic is_tick;
    logic drop;

    assign is_tick = (op == aahmd_pkg::OP_TICK);
    // a sample for the unused axis code changes nothing
    assign drop    = !is_tick && (axis == aahmd_pkg::AXIS_NONE);

    assign cmd_push    = push && !cmd_full && !drop;
    assign cmd.is_tick = is_tick;
    assign cmd.axis    = axis;
    assign cmd.delta   = $signed({1'b0, sample}) - $signed({1'b0, zero_offset});

endmodule

`default_nettype wire

// ===== sv/aahmd_back.sv =====
// back end: per-axis accumulation, averaging and change detection
`default_nettype none

module aahmd_back #(
    parameter int SAMPLES_PER_AVERAGE = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_empty,
    input  wire aahmd_pkg::cmd_t               cmd,
    output logic                               cmd_pop,
    input  wire logic [aahmd_pkg::THR_W-1:0]   hit_threshold,
    input  wire logic [aahmd_pkg::THR_W-1:0]   motion_threshold,
    input  wire logic                          res_full,
    output logic                               res_push,
    output aahmd_pkg::result_t                 res
);

    localparam int AVG_W   = aahmd_pkg::AVG_W;
    localparam int N       = SAMPLES_PER_AVERAGE;
    localparam int CNT_W   = $clog2(N + 1);
    localparam int SUM_W   = $clog2(N * 1024) + 1;
    localparam int MAG_W   = SUM_W - 1;
    localparam int SHIFT   = MAG_W + $clog2(N);
    localparam int RECIP_W = MAG_W + 1;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + N - 1) / N;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int NAX     = aahmd_pkg::NUM_AXES;

    logic signed [SUM_W-1:0] sums_reg   [NAX];
    logic signed [SUM_W-1:0] sums_next  [NAX];
    logic [CNT_W-1:0]        counts_reg [NAX];
    logic [CNT_W-1:0]        counts_next[NAX];
    logic signed [AVG_W-1:0] last_reg   [NAX];
    logic signed [AVG_W-1:0] last_next  [NAX];
    logic hit_flag_reg, hit_flag_next;
    logic motion_flag_reg, motion_flag_next;
    logic valid_flag_reg, valid_flag_next;

    logic signed [AVG_W-1:0] cur [NAX];
    logic go, hit, motion, any_nonzero;

    // truncating division by the sample count: reciprocal multiply on the magnitude
    function automatic logic signed [AVG_W-1:0] div_n(input logic signed [SUM_W-1:0] s);
        logic                    neg;
        logic [SUM_W-1:0]        mag_full;
        logic [MAG_W-1:0]        mag;
        logic [PROD_W-1:0]       prod;
        logic [AVG_W-1:0]        q;
        neg      = s[SUM_W-1];
        mag_full = neg ? SUM_W'(-s) : SUM_W'(s);
        mag      = mag_full[MAG_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(RECIP_W'(RECIP));
        q        = {1'b0, prod[SHIFT +: AVG_W-1]};
        return neg ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic [AVG_W-1:0] abs_diff(input logic signed [AVG_W-1:0] a,
                                                  input logic signed [AVG_W-1:0] b);
        logic signed [AVG_W:0] d;
        logic signed [AVG_W:0] ad;
        d  = (AVG_W + 1)'(a) - (AVG_W + 1)'(b);
        ad = d[AVG_W] ? -d : d;
        return ad[AVG_W-1:0];
    endfunction

    // a tick waits for room in the result queue, a sample never waits
    assign go      = !cmd_empty && (!cmd.is_tick || !res_full);
    assign cmd_pop = go;

    always_comb
    begin
        logic [AVG_W-1:0] diff;
        hit         = 1'b0;
        motion      = 1'b0;
        any_nonzero = 1'b0;
        for (int i = 0; i < NAX; i++)
        begin
            sums_next[i]   = sums_reg[i];
            counts_next[i] = counts_reg[i];
            last_next[i]   = last_reg[i];
            cur[i]         = last_reg[i];
            if (counts_reg[i] == CNT_W'(N))
            begin
                cur[i] = div_n(sums_reg[i]);
            end
            diff = abs_diff(cur[i], last_reg[i]);
            if (diff > hit_threshold)
            begin
                hit = 1'b1;
            end
            if (diff > motion_threshold)
            begin
                motion = 1'b1;
            end
            if (cur[i] != '0)
            begin
                any_nonzero = 1'b1;
            end
        end
        if (hit)
        begin
            motion = 1'b0;
        end

        hit_flag_next    = hit_flag_reg;
        motion_flag_next = motion_flag_reg;
        valid_flag_next  = valid_flag_reg;

        if (go && !cmd.is_tick)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                if ((cmd.axis == 2'(i)) && (counts_reg[i] < CNT_W'(N)))
                begin
                    counts_next[i] = counts_reg[i] + 1'b1;
                    sums_next[i]   = sums_reg[i] + SUM_W'(cmd.delta);
                end
            end
        end
        else if (go)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                last_next[i] = cur[i];
                if (counts_reg[i] == CNT_W'(N))
                begin
                    sums_next[i]   = '0;
                    counts_next[i] = '0;
                end
            end
            hit_flag_next    = hit_flag_reg | hit;
            motion_flag_next = motion_flag_reg | motion;
            valid_flag_next  = valid_flag_reg | any_nonzero;
        end
    end

    assign res_push           = go && cmd.is_tick;
    assign res.avg_x          = cur[0];
    assign res.avg_y          = cur[1];
    assign res.avg_z          = cur[2];
    assign res.hit_now        = hit;
    assign res.motion_now     = motion;
    assign res.hit_seen       = hit_flag_reg | hit;
    assign res.motion_seen    = motion_flag_reg | motion;
    assign res.averages_valid = valid_flag_reg | any_nonzero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                sums_reg[i]   <= '0;
                counts_reg[i] <= '0;
                last_reg[i]   <= '0;
            end
            hit_flag_reg    <= 1'b0;
            motion_flag_reg <= 1'b0;
            valid_flag_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NAX; i++)
            begin
                sums_reg[i]   <= sums_next[i];
                counts_reg[i] <= counts_next[i];
                last_reg[i]   <= last_next[i];
            end
            hit_flag_reg    <= hit_flag_next;
            motion_flag_reg <= motion_flag_next;
            valid_flag_reg  <= valid_flag_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/accel_average_hit_motion_detect_test.sv =====
// testbench of the accelerometer averaging and hit/motion detector
`default_nettype none

module accel_average_hit_motion_detect_test;

    localparam int SAMPLES       = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int AVG_W         = aahmd_pkg::AVG_W;
    localparam int SAMPLE_W      = aahmd_pkg::SAMPLE_W;
    localparam int THR_W         = aahmd_pkg::THR_W;
    localparam int AXIS_W        = aahmd_pkg::AXIS_W;
    localparam int NUM_AXES      = aahmd_pkg::NUM_AXES;
    localparam int APB_DW        = aahmd_pkg::APB_DW;
    localparam int APB_AW        = aahmd_pkg::APB_AW;

    // register index past the end of the map, writes to it must change nothing
    localparam logic [1:0] REG_BEYOND = 2'd3;

    logic                    clk     = 1'b0;
    logic                    rst_n   = 1'b0;
    logic                    push    = 1'b0;
    logic                    full;
    logic                    op      = aahmd_pkg::OP_SAMPLE;
    logic [AXIS_W-1:0]       axis    = aahmd_pkg::AXIS_X;
    logic [SAMPLE_W-1:0]     sample  = '0;
    logic                    empty;
    logic                    pop     = 1'b0;
    logic signed [AVG_W-1:0] avg_x;
    logic signed [AVG_W-1:0] avg_y;
    logic signed [AVG_W-1:0] avg_z;
    logic                    hit_now;
    logic                    motion_now;
    logic                    hit_seen;
    logic                    motion_seen;
    logic                    averages_valid;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_AW-1:0]       paddr   = '0;
    logic [APB_DW-1:0]       pwdata  = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // predictor copy of the block's registers and state
    logic [SAMPLE_W-1:0] zero_offset_q;
    logic [THR_W-1:0]    hit_thr_q;
    logic [THR_W-1:0]    motion_thr_q;
    int                  axis_sum   [NUM_AXES];
    int                  axis_count [NUM_AXES];
    int                  last_avg   [NUM_AXES];
    bit                  hit_sticky;
    bit                  motion_sticky;
    bit                  valid_sticky;

    aahmd_pkg::result_t expected_ticks [$];
    int      errors     = 0;
    int      cfg_errors = 0;
    int      ticks_sent = 0;
    int      send_idle  = 0;
    int      recv_idle  = 0;
    int      hold_count = 0;

    accel_average_hit_motion_detect #(
        .SAMPLES_PER_AVERAGE(SAMPLES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .op(op),
        .axis(axis),
        .sample(sample),
        .empty(empty),
        .pop(pop),
        .avg_x(avg_x),
        .avg_y(avg_y),
        .avg_z(avg_z),
        .hit_now(hit_now),
        .motion_now(motion_now),
        .hit_seen(hit_seen),
        .motion_seen(motion_seen),
        .averages_valid(averages_valid),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    function automatic void reset_averager();
        zero_offset_q = 10'd512;
        hit_thr_q     = 11'd200;
        motion_thr_q  = 11'd20;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            axis_sum[i]   = 0;
            axis_count[i] = 0;
            last_avg[i]   = 0;
        end
        hit_sticky    = 1'b0;
        motion_sticky = 1'b0;
        valid_sticky  = 1'b0;
    endfunction

    // samples accumulate; a tick averages the full axes and queues the expected report
    function automatic void predict_averages(logic t_op, logic [AXIS_W-1:0] t_axis,
                                             logic [SAMPLE_W-1:0] t_sample);
        int                 cur [NUM_AXES];
        int                 change;
        bit                 hit    = 1'b0;
        bit                 motion = 1'b0;
        aahmd_pkg::result_t report;
        if (t_op == aahmd_pkg::OP_SAMPLE)
        begin
            if (t_axis != aahmd_pkg::AXIS_NONE && axis_count[t_axis] < SAMPLES)
            begin
                axis_count[t_axis]++;
                axis_sum[t_axis] += int'(t_sample) - int'(zero_offset_q);
            end
            return;
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            cur[i] = last_avg[i];
            if (axis_count[i] == SAMPLES)
            begin
                // division truncates toward zero, as the block does
                cur[i]        = axis_sum[i] / SAMPLES;
                axis_sum[i]   = 0;
                axis_count[i] = 0;
            end
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            change = (cur[i] >= last_avg[i]) ? cur[i] - last_avg[i] : last_avg[i] - cur[i];
            if (change > int'(hit_thr_q))
                hit = 1'b1;
            else if (change > int'(motion_thr_q))
                motion = 1'b1;
        end
        // motion only counts when no axis made a hit
        if (hit)
            motion = 1'b0;
        hit_sticky    |= hit;
        motion_sticky |= motion;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            last_avg[i] = cur[i];
            if (cur[i] != 0)
                valid_sticky = 1'b1;
        end
        report.avg_x          = AVG_W'(cur[0]);
        report.avg_y          = AVG_W'(cur[1]);
        report.avg_z          = AVG_W'(cur[2]);
        report.hit_now        = hit;
        report.motion_now     = motion;
        report.hit_seen       = hit_sticky;
        report.motion_seen    = motion_sticky;
        report.averages_valid = valid_sticky;
        expected_ticks.push_back(report);
    endfunction

    function automatic void check_field(string name, logic signed [AVG_W-1:0] want,
                                        logic signed [AVG_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // every report leaving the block is matched against the oldest expectation
    always @(posedge clk)
    begin : check_reports
        aahmd_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_ticks.size() == 0)
            begin
                $error("report item with no tick pending");
                errors++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                check_field("avg_x", want.avg_x, avg_x);
                check_field("avg_y", want.avg_y, avg_y);
                check_field("avg_z", want.avg_z, avg_z);
                check_field("hit_now", want.hit_now, hit_now);
                check_field("motion_now", want.motion_now, motion_now);
                check_field("hit_seen", want.hit_seen, hit_seen);
                check_field("motion_seen", want.motion_seen, motion_seen);
                check_field("averages_valid", want.averages_valid, averages_valid);
            end
        end
    end

    // report side: random pops, or a long counted hold-off when asked for
    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_count)
            begin
                holds_done = hold_count;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // ends the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // push stays high after acceptance until the next item or wait_idle
    task automatic send_item(logic t_op, logic [AXIS_W-1:0] t_axis,
                             logic [SAMPLE_W-1:0] t_sample);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push   <= 1'b1;
        op     <= t_op;
        axis   <= t_axis;
        sample <= t_sample;
        do
            @(posedge clk);
        while (full);
        predict_averages(t_op, t_axis, t_sample);
        if (t_op == aahmd_pkg::OP_TICK)
            ticks_sent++;
    endtask

    task automatic send_tick();
        send_item(aahmd_pkg::OP_TICK, AXIS_W'($urandom_range(0, 3)),
                  SAMPLE_W'($urandom_range(0, 1023)));
    endtask

    task automatic fill_axis(logic [AXIS_W-1:0] which, logic [SAMPLE_W-1:0] value, int count);
        for (int i = 0; i < count; i++)
            send_item(aahmd_pkg::OP_SAMPLE, which, value);
    endtask

    // stop offering, drain all reports, then allow for samples still in flight
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(logic is_write, logic [APB_AW-1:0] addr,
                                logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write one register, mirror it in the predictor and read it back unless it is unmapped
    task automatic config_reg(logic [1:0] index, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] readback;
        logic [APB_DW-1:0] want;
        apb_transfer(1'b1, {index, 2'b00}, value, readback);
        unique case (index)
            aahmd_pkg::REG_ZERO_OFFSET: zero_offset_q = value[SAMPLE_W-1:0];
            aahmd_pkg::REG_HIT_THR:     hit_thr_q     = value[THR_W-1:0];
            aahmd_pkg::REG_MOTION_THR:  motion_thr_q  = value[THR_W-1:0];
            default:                    ;
        endcase
        if (index != REG_BEYOND)
        begin
            if (index == aahmd_pkg::REG_ZERO_OFFSET)
                want = APB_DW'(zero_offset_q);
            else if (index == aahmd_pkg::REG_HIT_THR)
                want = APB_DW'(hit_thr_q);
            else
                want = APB_DW'(motion_thr_q);
            apb_transfer(1'b0, {index, 2'b00}, '0, readback);
            if (readback !== want)
            begin
                $error("prdata: expected %0d, got %0d", want, readback);
                cfg_errors++;
            end
        end
    endtask

    task automatic set_registers(int offset, int hit_thr, int motion_thr);
        wait_idle();
        config_reg(aahmd_pkg::REG_ZERO_OFFSET, APB_DW'(offset));
        config_reg(aahmd_pkg::REG_HIT_THR, APB_DW'(hit_thr));
        config_reg(aahmd_pkg::REG_MOTION_THR, APB_DW'(motion_thr));
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_reading(int v);
        if (v < 0)
            return '0;
        if (v > 1023)
            return '1;
        return SAMPLE_W'(v);
    endfunction

    // junk in the upper data bits must be masked; the unmapped slot is harmless
    task automatic test_registers();
        wait_idle();
        config_reg(aahmd_pkg::REG_ZERO_OFFSET, $urandom);
        config_reg(aahmd_pkg::REG_HIT_THR, $urandom);
        config_reg(aahmd_pkg::REG_MOTION_THR, $urandom);
        config_reg(REG_BEYOND, $urandom);
        fill_axis(aahmd_pkg::AXIS_X, SAMPLE_W'($urandom_range(0, 1023)), SAMPLES);
        send_tick();
    endtask

    task automatic test_directed();
        set_registers(512, 200, 20);
        send_tick();
        send_item(aahmd_pkg::OP_SAMPLE, aahmd_pkg::AXIS_NONE, 10'd1023);
        send_tick();
        // change equal to the motion threshold is not motion
        fill_axis(aahmd_pkg::AXIS_X, 10'd532, SAMPLES);
        send_tick();
        // one above it is
        fill_axis(aahmd_pkg::AXIS_X, 10'd553, SAMPLES);
        // y sums to -17, which averages to -1 and not -2
        fill_axis(aahmd_pkg::AXIS_Y, 10'd512, SAMPLES - 1);
        send_item(aahmd_pkg::OP_SAMPLE, aahmd_pkg::AXIS_Y, 10'd495);
        // z only half full keeps its old average and its partial sum
        fill_axis(aahmd_pkg::AXIS_Z, 10'd1023, SAMPLES / 2);
        send_tick();
        // one sample past full is dropped
        fill_axis(aahmd_pkg::AXIS_Z, 10'd1023, SAMPLES / 2 + 1);
        send_tick();
        // change equal to the hit threshold is motion only, one above is a hit
        fill_axis(aahmd_pkg::AXIS_X, 10'd753, SAMPLES);
        send_tick();
        fill_axis(aahmd_pkg::AXIS_X, 10'd954, SAMPLES);
        send_tick();
        // full-scale swing with the hit threshold at its top and the motion threshold at 2045
        set_registers(0, 2047, 2045);
        fill_axis(aahmd_pkg::AXIS_X, 10'd1023, SAMPLES);
        fill_axis(aahmd_pkg::AXIS_Y, 10'd0, SAMPLES);
        send_tick();
        set_registers(1023, 2047, 2045);
        fill_axis(aahmd_pkg::AXIS_X, 10'd0, SAMPLES);
        send_tick();
        // zero thresholds: any change at all is a hit
        set_registers(1023, 0, 0);
        fill_axis(aahmd_pkg::AXIS_X, 10'd1023, SAMPLES);
        send_tick();
    endtask

    // mostly complete frames with drifting levels, some short or overfull, some noise
    task automatic test_random(int offset, int hit_thr, int motion_thr,
                               int item_goal, int tick_goal);
        int                  items;
        int                  first_tick;
        int                  spread;
        int                  jitter;
        int                  pick;
        int                  remaining;
        int                  saved_idle;
        int                  level [NUM_AXES];
        int                  left  [NUM_AXES];
        logic [AXIS_W-1:0]   n_axis;
        logic                n_op;
        set_registers(offset, hit_thr, motion_thr);
        items      = 0;
        first_tick = ticks_sent;
        for (int a = 0; a < NUM_AXES; a++)
            level[a] = int'($urandom_range(0, 1023));
        while (items < item_goal || ticks_sent - first_tick < tick_goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                n_op   = 1'($urandom_range(0, 1));
                n_axis = AXIS_W'($urandom_range(0, 3));
                send_item(n_op, n_axis, SAMPLE_W'($urandom_range(0, 1023)));
                if (n_op == aahmd_pkg::OP_TICK || n_axis != aahmd_pkg::AXIS_NONE)
                    items++;
            end
            else
            begin
                saved_idle = send_idle;
                if ($urandom_range(0, 3) == 0)
                    send_idle = 0;
                // step sizes from tiny to full scale so changes land around the thresholds
                spread    = (1 << $urandom_range(0, 10)) - 1;
                jitter    = ($urandom_range(0, 3) == 0) ? 1023 : int'($urandom_range(0, 8));
                remaining = 0;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    level[a] = int'(clamp_reading(level[a]
                                                  + int'($urandom_range(0, 2 * spread))
                                                  - spread));
                    case ($urandom_range(0, 19)) inside
                        [0:2]:   left[a] = int'($urandom_range(0, SAMPLES - 1));
                        [3:5]:   left[a] = SAMPLES + int'($urandom_range(1, 4));
                        default: left[a] = SAMPLES;
                    endcase
                    remaining += left[a];
                end
                while (remaining > 0)
                begin
                    do
                        pick = int'($urandom_range(0, NUM_AXES - 1));
                    while (left[pick] == 0);
                    send_item(aahmd_pkg::OP_SAMPLE, AXIS_W'(pick),
                              clamp_reading(level[pick] + int'($urandom_range(0, 2 * jitter))
                                            - jitter));
                    left[pick]--;
                    remaining--;
                    items++;
                end
                send_tick();
                items++;
                send_idle = saved_idle;
            end
        end
    endtask

    // reports are held back while ticks keep coming, so the block has to stall its input
    task automatic test_backpressure();
        hold_count++;
        for (int i = 0; i < 48; i++)
        begin
            send_item(aahmd_pkg::OP_SAMPLE, AXIS_W'($urandom_range(0, 2)),
                      SAMPLE_W'($urandom_range(0, 1023)));
            send_tick();
        end
    endtask

    initial
    begin
        reset_averager();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle = 7;
        recv_idle = 57;
        test_registers();
        test_directed();
        test_random(int'($urandom_range(0, 1023)), int'($urandom_range(100, 400)),
                    int'($urandom_range(5, 60)), 220, 4);
        test_random(1023, 2047, 0, 100, 2);

        send_idle = 57;
        recv_idle = 7;
        test_random(0, 0, 2047, 100, 2);
        test_random(int'($urandom_range(0, 1023)), int'($urandom_range(0, 2047)),
                    int'($urandom_range(0, 2047)), 220, 4);

        send_idle = 0;
        recv_idle = 0;
        test_random(512, 200, 20, 260, 5);
        test_backpressure();

        wait_idle();
        if (errors == 0 && cfg_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/aahmd_pkg.sv
sv/aahmd_fifo.sv
sv/aahmd_front.sv
sv/aahmd_back.sv
sv/accel_average_hit_motion_detect.sv
tb/sv/accel_average_hit_motion_detect_test.sv
